// ===== rtl/crc32bs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32bs_pkg
// Shared types, constants and the byte fold function for the reflected
// CRC-32 byte stream unit.
// ----------------------------------------------------------------------------
package crc32bs_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;

    localparam logic [CrcWidth-1:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CrcWidth-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    typedef logic [CrcWidth-1:0]  t_crc;
    typedef logic [ByteWidth-1:0] t_byte;

    // One input transaction as held in the input register
    typedef struct packed {
        t_byte data_byte;
        logic  first_byte;
        logic  last_byte;
        t_crc  seed_value;
    } t_item;

    // Fold one byte into the CRC, LSB first: eight shift-xor steps
    function automatic t_crc fold_byte(input t_crc crc, input t_byte data);
        t_crc c;
        c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
        for (int k = 0; k < ByteWidth; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc32_byte_stream_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_byte_stream_unit
// Byte-serial reflected CRC-32 (poly 0xEDB88320) with seeded chaining.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one message byte per
//   transaction with first/last marks and a seed. On a first byte a zero
//   seed starts from all ones and the result is inverted; a nonzero seed
//   continues from that value and the result is given raw.
//   Output channel (o_out_valid / i_out_stall) carries one CRC per message,
//   produced only by the byte marked last.
//   Throughput: one byte per clock while o_in_stall is low; the byte
//   fold from the input register to the result register is combinational.
//   o_out_valid is set with the result register as the last byte is consumed.
//   Reset: clears both registers' valid flags, the running CRC to all ones
//   and the mode to fresh start.
//   Stall: a waiting result holds; further non-last bytes still advance.
//   A last byte waits in the input register until the result slot frees,
//   and o_in_stall then rises once the input register is also full.
// ----------------------------------------------------------------------------
module crc32_byte_stream_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  crc32bs_pkg::t_byte     i_data_byte,
    input  logic                   i_first_byte,
    input  logic                   i_last_byte,
    input  crc32bs_pkg::t_crc      i_seed_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output crc32bs_pkg::t_crc      o_crc_value
);
    import crc32bs_pkg::*;

    logic  r_in_valid;
    logic  n_in_valid;
    t_item r_item;
    logic  r_out_valid;
    logic  n_out_valid;
    t_crc  r_crc_value;

    logic  w_in_take;
    logic  w_out_free;
    logic  w_consume;
    t_crc  w_result;

    // Handshake control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_consume  = r_in_valid && (!r_item.last_byte || w_out_free);
    assign o_in_stall = r_in_valid && !w_consume;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_consume && r_item.last_byte) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item <= '{data_byte:  i_data_byte,
                        first_byte: i_first_byte,
                        last_byte:  i_last_byte,
                        seed_value: i_seed_value};
        end
    end

    // Fold and state
    crc32bs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_consume),
        .i_item   (r_item),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && r_item.last_byte) begin
            r_crc_value <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc_value;

    // Checks
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_item.last_byte && r_out_valid))
        else $error("input stalled without a blocked last byte");

    a_last_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_item.last_byte) |=> r_out_valid)
        else $error("last byte consumed but no result registered");

    a_held_item_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_consume) |=> (r_in_valid && $stable(r_item)))
        else $error("unconsumed input transaction was lost or changed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(w_consume && r_item.last_byte))
        else $error("result register overwritten while stalled");

endmodule

// ===== rtl/crc32bs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32bs_core
// Running CRC and seed mode. Folds one byte per step and forms the final
// value (inverted for a fresh start, raw for a chained seed).
// ----------------------------------------------------------------------------
module crc32bs_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  crc32bs_pkg::t_item  i_item,
    output crc32bs_pkg::t_crc   o_result
);
    import crc32bs_pkg::*;

    t_crc r_running_crc;
    t_crc n_running_crc;
    logic r_continue_mode;
    logic n_continue_mode;

    t_crc w_start_crc;
    logic w_start_mode;
    t_crc w_folded;

    // Seed selection on the first byte of a message
    always_comb begin
        if (i_item.first_byte) begin
            if (i_item.seed_value != '0) begin
                w_start_crc  = i_item.seed_value;
                w_start_mode = 1'b1;
            end else begin
                w_start_crc  = CRC_ALL_ONES;
                w_start_mode = 1'b0;
            end
        end else begin
            w_start_crc  = r_running_crc;
            w_start_mode = r_continue_mode;
        end
    end

    assign w_folded = fold_byte(w_start_crc, i_item.data_byte);
    assign o_result = w_start_mode ? w_folded : ~w_folded;

    // Next state: back to fresh defaults after the last byte
    always_comb begin
        n_running_crc   = r_running_crc;
        n_continue_mode = r_continue_mode;
        if (i_step) begin
            if (i_item.last_byte) begin
                n_running_crc   = CRC_ALL_ONES;
                n_continue_mode = 1'b0;
            end else begin
                n_running_crc   = w_folded;
                n_continue_mode = w_start_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_crc   <= CRC_ALL_ONES;
            r_continue_mode <= 1'b0;
        end else begin
            r_running_crc   <= n_running_crc;
            r_continue_mode <= n_continue_mode;
        end
    end

endmodule
